>>> rtl/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared constants, codes and controller/datapath interface types of the
// positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int CAPACITY_DEF = 32;

   // word field widths
   localparam int MODE_W   = 3;
   localparam int POS_W    = 6;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 6;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DUMP   = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

   // cursor update select
   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_LEN_M1,
      CUR_POS,
      CUR_ZERO,
      CUR_DEC,
      CUR_INC
   } cur_sel_type;

   // length update select
   typedef enum logic [1:0] {
      LEN_HOLD,
      LEN_INC,
      LEN_DEC
   } len_sel_type;

   // new-value write select
   typedef enum logic [1:0] {
      PUT_NONE,
      PUT_TAIL,
      PUT_POS
   } put_sel_type;

   typedef struct packed {
      logic                op_load;
      cur_sel_type         cur_sel;
      logic                rd_en;
      logic                mv_wr;
      logic                wadr_load;
      put_sel_type         put_sel;
      len_sel_type         len_sel;
      logic                st_load;
      logic [STATUS_W-1:0] st_code;
      logic                out_single;
      logic                out_dump;
   } ple_cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              bad_pos;
      logic              full;
      logic              empty;
      logic              pos_is_len;
      logic              cur_at_pos_m1;
      logic              cur_at_len_m1;
      logic              out_free;
   } ple_stat_type;

endpackage

>>> rtl/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY signed words: push, pop, insert at
// position, remove at position and dump, one operation per request word.
// ----------------------------------------------------------------------------
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  req     | req_valid/ready, mode, position, value        | in
//  rsp     | rsp_valid/ready, status, element,             | out
//          | element_position, length, final_flag          |
//
// Steps: push, pop, refused and unused operations pass accept, decode and
//   result. Insert and remove then move the entries behind the position,
//   one entry per cycle through the entry RAM's separate write and read
//   ports; remove at the tail moves none. Dump makes one RAM read and one
//   result load per element.
// Reset: synchronous, clears the length and the control state; the entry
//   RAM is not cleared, only entries below the length are ever read.
// Stalls: a held result blocks only the next result load; a new request
//   word is taken while the previous result still waits.
//
module positional_list_engine
   import ple_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [MODE_W-1:0]       req_mode,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,

   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic signed [VAL_W-1:0] rsp_element,
   output logic [POS_W-1:0]        rsp_element_position,
   output logic [LEN_W-1:0]        rsp_length,
   output logic                    rsp_final_flag
);

   ple_cmd_type  cmd;
   ple_stat_type stat;

   // sequencer: one-hot FSM, decodes the word and drives the datapath
   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: word registers, length, cursor, entry RAM, result register
   ple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_mode             (req_mode),
      .req_position         (req_position),
      .req_value            (req_value),
      .cmd                  (cmd),
      .stat                 (stat),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_element          (rsp_element),
      .rsp_element_position (rsp_element_position),
      .rsp_length           (rsp_length),
      .rsp_final_flag       (rsp_final_flag)
   );

endmodule

>>> rtl/ple_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/ple_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_datapath
// Operation registers, length, cursor, entry RAM and result register.
// ----------------------------------------------------------------------------
module ple_datapath
   import ple_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [VAL_W-1:0]    req_value,
   input  ple_cmd_type                cmd,
   output ple_stat_type               stat,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [VAL_W-1:0]    rsp_element,
   output logic [POS_W-1:0]           rsp_element_position,
   output logic [LEN_W-1:0]           rsp_length,
   output logic                       rsp_final_flag
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [MODE_W-1:0]   mode_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [VAL_W-1:0]    val_ff;
   logic [CW-1:0]       len_ff, len_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [AW-1:0]       wadr_ff;
   logic                pend_ff;
   logic [STATUS_W-1:0] st_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [VAL_W-1:0]    rsp_element_ff;
   logic [POS_W-1:0]    rsp_epos_ff;
   logic [LEN_W-1:0]    rsp_length_ff;
   logic                rsp_final_ff;

   logic [CMPW-1:0]     pos_x, len_x, cur_p1;
   logic [CW-1:0]       len_m1;
   logic [POS_W-1:0]    pos_m1;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [VAL_W-1:0]    ram_wdata;
   logic [VAL_W-1:0]    ram_rdata;
   logic                out_free;

   assign pos_x  = CMPW'(pos_ff);
   assign len_x  = CMPW'(len_ff);
   assign cur_p1 = CMPW'(cur_ff) + CMPW'(1);
   assign len_m1 = len_ff - CW'(1);
   assign pos_m1 = pos_ff - POS_W'(1);

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat.mode          = mode_ff;
      stat.bad_pos       = (pos_ff == '0) || (pos_x > len_x);
      stat.full          = (len_ff >= CAP_C);
      stat.empty         = (len_ff == '0);
      stat.pos_is_len    = (pos_x == len_x);
      stat.cur_at_pos_m1 = (cur_p1 == pos_x);
      stat.cur_at_len_m1 = (cur_p1 == len_x);
      stat.out_free      = out_free;
   end

   // operation word; held for the whole operation
   always_ff @(posedge clock) begin
      if (cmd.op_load) begin
         mode_ff <= req_mode;
         pos_ff  <= req_position;
         val_ff  <= req_value;
      end
      if (cmd.st_load) begin
         st_ff <= cmd.st_code;
      end
      if (cmd.wadr_load) begin
         wadr_ff <= (mode_ff == MODE_INSERT) ? (cur_ff + AW'(1)) : (cur_ff - AW'(1));
      end
      cur_ff <= cur_in;
   end

   always_comb begin
      case (cmd.cur_sel)
         CUR_LEN_M1: cur_in = len_m1[AW-1:0];
         CUR_POS:    cur_in = pos_ff[AW-1:0];
         CUR_ZERO:   cur_in = '0;
         CUR_DEC:    cur_in = cur_ff - AW'(1);
         CUR_INC:    cur_in = cur_ff + AW'(1);
         default:    cur_in = cur_ff;
      endcase
   end

   always_comb begin
      case (cmd.len_sel)
         LEN_INC: len_in = len_ff + CW'(1);
         LEN_DEC: len_in = len_m1;
         default: len_in = len_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         pend_ff <= cmd.wadr_load;
      end
   end

   // write port: new value, or a shifted entry one step behind its read
   always_comb begin
      case (cmd.put_sel)
         PUT_TAIL: begin
            ram_we    = 1'b1;
            ram_waddr = len_ff[AW-1:0];
            ram_wdata = val_ff;
         end
         PUT_POS: begin
            ram_we    = 1'b1;
            ram_waddr = pos_m1[AW-1:0];
            ram_wdata = val_ff;
         end
         default: begin
            ram_we    = cmd.mv_wr && pend_ff;
            ram_waddr = wadr_ff;
            ram_wdata = ram_rdata;
         end
      endcase
   end

   ple_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.rd_en),
      .rd_addr (cur_ff),
      .rd_data (ram_rdata)
   );

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_single) begin
         rsp_status_ff  <= st_ff;
         rsp_element_ff <= '0;
         rsp_epos_ff    <= '0;
         rsp_length_ff  <= LEN_W'(len_ff);
         rsp_final_ff   <= 1'b1;
      end else if (cmd.out_dump) begin
         rsp_status_ff  <= ST_OK;
         rsp_element_ff <= ram_rdata;
         rsp_epos_ff    <= POS_W'(cur_p1);
         rsp_length_ff  <= LEN_W'(len_ff);
         rsp_final_ff   <= stat.cur_at_len_m1;
      end
   end

   assign rsp_valid_in = (cmd.out_single || cmd.out_dump) ? 1'b1 :
                         (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_element          = $signed(rsp_element_ff);
   assign rsp_element_position = rsp_epos_ff;
   assign rsp_length           = rsp_length_ff;
   assign rsp_final_flag       = rsp_final_ff;

   // shift moves never write the entry being read
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && cmd.rd_en) |-> (ram_waddr != cur_ff))
      else $error("ple: RAM write and read hit the same entry");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CAP_C)
      else $error("ple: length above capacity");

   // a result is only loaded into a free result register, and then stays valid
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_single || cmd.out_dump) |-> (out_free && !(cmd.out_single && cmd.out_dump)))
      else $error("ple: result register overwritten");

   a_out_shown: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_single || cmd.out_dump) |=> rsp_valid_ff)
      else $error("ple: loaded result not presented");

endmodule

>>> rtl/ple_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Operation sequencer: decodes the word and steps the datapath.
// ----------------------------------------------------------------------------
module ple_ctrl
   import ple_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ple_stat_type stat,
   output ple_cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_DECODE   = 10'b00_0000_0010,
      S_INS_RD   = 10'b00_0000_0100,
      S_INS_LAST = 10'b00_0000_1000,
      S_INS_PUT  = 10'b00_0001_0000,
      S_REM_RD   = 10'b00_0010_0000,
      S_REM_LAST = 10'b00_0100_0000,
      S_DUMP_RD  = 10'b00_1000_0000,
      S_DUMP_OUT = 10'b01_0000_0000,
      S_RESP     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op_load = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.st_load = 1'b1;
            cmd.st_code = ST_OK;
            state_in    = S_RESP;
            case (stat.mode)
               MODE_PUSH: begin
                  if (stat.full) begin
                     cmd.st_code = ST_FULL;
                  end else begin
                     cmd.put_sel = PUT_TAIL;
                     cmd.len_sel = LEN_INC;
                  end
               end
               MODE_POP: begin
                  if (stat.empty) begin
                     cmd.st_code = ST_EMPTY;
                  end else begin
                     cmd.len_sel = LEN_DEC;
                  end
               end
               MODE_INSERT: begin
                  if (stat.bad_pos) begin
                     cmd.st_code = ST_BADPOS;
                  end else if (stat.full) begin
                     cmd.st_code = ST_FULL;
                  end else begin
                     cmd.cur_sel = CUR_LEN_M1;
                     state_in    = S_INS_RD;
                  end
               end
               MODE_REMOVE: begin
                  if (stat.bad_pos) begin
                     cmd.st_code = ST_BADPOS;
                  end else if (stat.pos_is_len) begin
                     cmd.len_sel = LEN_DEC;
                  end else begin
                     cmd.cur_sel = CUR_POS;
                     state_in    = S_REM_RD;
                  end
               end
               MODE_DUMP: begin
                  if (stat.empty) begin
                     cmd.st_code = ST_EMPTY;
                  end else begin
                     cmd.cur_sel = CUR_ZERO;
                     state_in    = S_DUMP_RD;
                  end
               end
               default: begin
                  cmd.st_code = ST_OK;
               end
            endcase
         end
         S_INS_RD: begin
            cmd.rd_en     = 1'b1;
            cmd.mv_wr     = 1'b1;
            cmd.wadr_load = 1'b1;
            if (stat.cur_at_pos_m1) begin
               state_in = S_INS_LAST;
            end else begin
               cmd.cur_sel = CUR_DEC;
            end
         end
         S_INS_LAST: begin
            cmd.mv_wr = 1'b1;
            state_in  = S_INS_PUT;
         end
         S_INS_PUT: begin
            cmd.put_sel = PUT_POS;
            cmd.len_sel = LEN_INC;
            state_in    = S_RESP;
         end
         S_REM_RD: begin
            cmd.rd_en     = 1'b1;
            cmd.mv_wr     = 1'b1;
            cmd.wadr_load = 1'b1;
            if (stat.cur_at_len_m1) begin
               state_in = S_REM_LAST;
            end else begin
               cmd.cur_sel = CUR_INC;
            end
         end
         S_REM_LAST: begin
            cmd.mv_wr   = 1'b1;
            cmd.len_sel = LEN_DEC;
            state_in    = S_RESP;
         end
         S_DUMP_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            if (stat.out_free) begin
               cmd.out_dump = 1'b1;
               if (stat.cur_at_len_m1) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.cur_sel = CUR_INC;
                  state_in    = S_DUMP_RD;
               end
            end
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.out_single = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // a word is taken only by an idle sequencer, which then decodes it
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("ple: accepted word not decoded");

   // shift loop never updates the length before its last move
   a_len_after_moves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_RD || state_ff == S_REM_RD) |-> (cmd.len_sel == LEN_HOLD))
      else $error("ple: length changed during shift");

   a_one_result_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_single |=> (state_ff == S_IDLE))
      else $error("ple: single result not final");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the positional list engine against a queue-based list predictor.
// Covers directed empty/edge/full cases, a long output stall that backs up
// the request side, and a long random mix of list operations. Gaps on both
// channels are random per word, outside the stretches that run with none.
// ----------------------------------------------------------------------------
module testbench;
   import ple_pkg::*;

   localparam int CAPACITY     = CAPACITY_DEF;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int HOLD_CYCLES  = 300;
   // leave room past the longest dump
   localparam int TAIL_CYCLES  = 4 * CAPACITY + 16;
   localparam int RANDOM_WORDS = 280;

   // mode codes the block ignores
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic signed [VAL_W-1:0] element;
      logic [POS_W-1:0]        element_position;
      logic [LEN_W-1:0]        length;
      logic                    final_flag;
   } list_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [MODE_W-1:0]       req_mode = MODE_PUSH;
   logic [POS_W-1:0]        req_position = '0;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic signed [VAL_W-1:0] rsp_element;
   logic [POS_W-1:0]        rsp_element_position;
   logic [LEN_W-1:0]        rsp_length;
   logic                    rsp_final_flag;

   // predictor state: list contents, position 1 first
   logic signed [VAL_W-1:0] list_words[$];
   list_result_type         pending_results[$];
   list_result_type         oldest_result;

   int  mismatches = 0;
   int  cycle_count = 0;
   int  rsp_stall = 0;
   int  hold_left = 0;
   bit  send_idle = 1'b1;
   bit  recv_idle = 1'b1;

   positional_list_engine dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_position         (req_position),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_element          (rsp_element),
      .rsp_element_position (rsp_element_position),
      .rsp_length           (rsp_length),
      .rsp_final_flag       (rsp_final_flag)
   );

   always #6 clock = ~clock;

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("positional_list_engine verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic list_result_type make_result(input logic [STATUS_W-1:0] st,
                                                   input logic signed [VAL_W-1:0] elem,
                                                   input int epos, input bit last);
      list_result_type r;
      r.status           = st;
      r.element          = elem;
      r.element_position = POS_W'(epos);
      r.length           = LEN_W'(list_words.size());
      r.final_flag       = last;
      return r;
   endfunction

   // Apply one accepted word to the list and queue what it should produce.
   task automatic apply_list_op(input logic [MODE_W-1:0] mode,
                                input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val);
      logic [STATUS_W-1:0] st;
      int                  len;
      int                  p;
      st  = ST_OK;
      len = list_words.size();
      p   = int'(pos);
      case (mode)
         MODE_PUSH: begin
            if (len >= CAPACITY) st = ST_FULL;
            else list_words.push_back(val);
         end
         MODE_POP: begin
            if (len == 0) st = ST_EMPTY;
            else void'(list_words.pop_back());
         end
         MODE_INSERT: begin
            // position is checked before fullness
            if (p < 1 || p > len) st = ST_BADPOS;
            else if (len >= CAPACITY) st = ST_FULL;
            else list_words.insert(p - 1, val);
         end
         MODE_REMOVE: begin
            if (p < 1 || p > len) st = ST_BADPOS;
            else list_words.delete(p - 1);
         end
         MODE_DUMP: begin
            if (len == 0) st = ST_EMPTY;
            else begin
               for (int i = 0; i < len; i++)
                  pending_results.push_back(make_result(ST_OK, list_words[i], i + 1,
                                                        i + 1 == len));
               return;
            end
         end
         default: ;   // spare modes: no change, plain ok result
      endcase
      pending_results.push_back(make_result(st, '0, 0, 1'b1));
   endtask

   // ------------------------------------------------------------------------
   // result side: ready with random stalls, plus a long hold when asked
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (rsp_stall > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result word: status %0d length %0d", rsp_status, rsp_length);
            mismatches++;
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("status", oldest_result.status, rsp_status);
            check_field("element", oldest_result.element, rsp_element);
            check_field("element_position", oldest_result.element_position,
                        rsp_element_position);
            check_field("length", oldest_result.length, rsp_length);
            check_field("final_flag", oldest_result.final_flag, rsp_final_flag);
         end
         rsp_stall = recv_idle ? $urandom_range(0, 7) : 0;
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // Entered and left at a falling edge; valid stays up across back-to-back
   // words and is only dropped by a gap or by release_request.
   // ------------------------------------------------------------------------
   task automatic send_word(input logic [MODE_W-1:0] mode,
                            input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] val);
      int gap;
      gap = send_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= mode;
      req_position <= pos;
      req_value    <= val;
      do @(posedge clock); while (!req_ready);
      apply_list_op(mode, pos, val);
      @(negedge clock);
   endtask

   task automatic release_request();
      req_valid <= 1'b0;
   endtask

   function automatic logic signed [VAL_W-1:0] draw_value();
      case ($urandom_range(0, 15))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_empty_list();
      send_word(MODE_POP, 6'd0, '0);
      send_word(MODE_DUMP, 6'd0, '0);
      send_word(MODE_INSERT, 6'd1, 32'sh1234_5678);
      send_word(MODE_REMOVE, 6'd0, '0);
      send_word(MODE_REMOVE, 6'd63, '0);
      send_word(MODE_INSERT, 6'd63, '1);
   endtask

   task automatic test_edge_ops();
      send_word(MODE_PUSH, 6'd0, 32'sh7FFF_FFFF);
      send_word(MODE_PUSH, 6'd21, 32'sh8000_0000);
      send_word(MODE_PUSH, 6'd42, '0);
      send_word(MODE_PUSH, 6'd63, '1);
      send_word(MODE_INSERT, 6'd0, 32'sh0BAD_0BAD);
      send_word(MODE_INSERT, 6'd5, 32'sh0BAD_0BAD);     // one past the end
      send_word(MODE_INSERT, 6'd1, 32'sh5555_5555);     // new head
      send_word(MODE_INSERT, 6'd5, 32'shAAAA_AAAA);     // in front of the tail
      send_word(MODE_DUMP, 6'd0, '0);
      send_word(MODE_REMOVE, 6'd6, '0);                 // tail
      send_word(MODE_REMOVE, 6'd1, '0);                 // head
      send_word(MODE_REMOVE, 6'd63, '0);
      for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++)
         send_word(MODE_W'(m), 6'd42, draw_value());
      send_word(MODE_POP, 6'd0, '0);
      send_word(MODE_DUMP, 6'd0, '0);
   endtask

   task automatic test_full_list();
      while (list_words.size() < CAPACITY)
         send_word(MODE_PUSH, POS_W'($urandom_range(0, 63)), draw_value());
      send_word(MODE_PUSH, 6'd0, 32'sh0F0F_0F0F);
      send_word(MODE_INSERT, POS_W'(CAPACITY), 32'sh0F0F_0F0F);   // valid pos, but full
      send_word(MODE_INSERT, 6'd0, 32'sh0F0F_0F0F);              // bad pos wins over full
      send_word(MODE_INSERT, POS_W'(CAPACITY + 1), 32'sh0F0F_0F0F);
      send_word(MODE_DUMP, 6'd0, '0);
      send_word(MODE_REMOVE, POS_W'(CAPACITY), '0);
      send_word(MODE_INSERT, 6'd1, draw_value());
      send_word(MODE_DUMP, 6'd0, '0);
      while (list_words.size() > 0)
         send_word(MODE_POP, 6'd0, '0);
      send_word(MODE_POP, 6'd0, '0);
   endtask

   // Output held off for a long stretch while words keep coming, so the
   // engine backs up and drops req_ready.
   task automatic test_backpressure();
      send_idle = 1'b0;
      release_request();
      @(posedge clock);
      hold_left = HOLD_CYCLES;
      @(negedge clock);
      for (int i = 0; i < 10; i++)
         send_word(MODE_PUSH, 6'd0, draw_value());
      send_word(MODE_DUMP, 6'd0, '0);
      send_word(MODE_REMOVE, 6'd3, '0);
      send_idle = 1'b1;
   endtask

   task automatic test_random_ops(input int count);
      int                      target;
      int                      len;
      int                      pick;
      bit                      grow;
      logic [MODE_W-1:0]       mode;
      logic [POS_W-1:0]        pos;
      target = CAPACITY / 2;
      for (int n = 0; n < count; n++) begin
         // stretches with no gaps on one or both sides
         send_idle = !(n >= 100 && n < 160);
         recv_idle = !(n >= 130 && n < 200);
         if (n % 30 == 0)
            target = ($urandom_range(0, 3) == 0) ? CAPACITY * $urandom_range(0, 1)
                                                 : $urandom_range(0, CAPACITY);
         len  = list_words.size();
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            mode = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         end else if (pick < 12) begin
            mode = MODE_DUMP;
         end else begin
            grow = $urandom_range(0, 99) < ((len < target) ? 75 : 25);
            if (grow) mode = $urandom_range(0, 1) ? MODE_PUSH : MODE_INSERT;
            else      mode = $urandom_range(0, 1) ? MODE_POP : MODE_REMOVE;
         end
         if (len == 0 || $urandom_range(0, 99) < 12)
            pos = POS_W'($urandom_range(0, 63));
         else
            pos = POS_W'($urandom_range(1, len));
         send_word(mode, pos, draw_value());
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_list();
      test_edge_ops();
      test_full_list();
      test_backpressure();
      test_random_ops(RANDOM_WORDS);
      release_request();

      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("positional_list_engine verification clean");
      end else begin
         $display("positional_list_engine verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/ple_pkg.sv
rtl/ple_ram.sv
rtl/ple_datapath.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine.sv
dv/testbench.sv
